// ===== rtl/core/scoh_pkg.sv =====
// Shared types, codes and defaults for the scan occupancy histogram.
// Used by every module of the block; depends on nothing.
`default_nettype none

package scoh_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 336;
  localparam int MAX_BINS_DEF  = 32;
  localparam int MAX_STEPS_DEF = 256;

  localparam int COLUMN_W = 8;
  localparam int ROW_W    = 9;
  localparam int EVENT_W  = 32;
  localparam int SIDX_W   = 8;
  localparam int PARAM_W  = 16;
  localparam int RBIN_W   = 5;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 32;
  localparam int BIN_W    = 6;
  localparam int DIFF_W   = PARAM_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HIT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COLUMN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ROW    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BIN    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CORR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PARAMETER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE   = 2'd3;

  typedef struct packed {
    logic               scan_enabled;
    logic [8:0]         step_count;
    logic [PARAM_W-1:0] min_parameter;
    logic [5:0]         bins_in_use;
  } cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_TAIL_RD,
    S_TAIL_CMP,
    S_BIN,
    S_ADDR,
    S_MEM_RD,
    S_MEM_CHK,
    S_DONE
  } state_t;

  function automatic logic bin_ok(input logic [DIFF_W-1:0] b, input logic [5:0] biu,
                                  input int unsigned max_bins);
    return (b < {{(DIFF_W-6){1'b0}}, biu}) && (32'(b) < max_bins);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scoh_step_table.sv =====
// Scan-step table: first event number and parameter value of each step.
// One write port, two registered read ports; uses scoh_pkg.
`default_nettype none

module scoh_step_table
  import scoh_pkg::*;
#(
  parameter int DEPTH  = MAX_STEPS_DEF,
  parameter int ADDR_W = $clog2(MAX_STEPS_DEF)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  wa,
  input  wire logic [EVENT_W-1:0] wev,
  input  wire logic [PARAM_W-1:0] wpar,
  input  wire logic [ADDR_W-1:0]  ra0,
  input  wire logic [ADDR_W-1:0]  ra1,
  output logic      [EVENT_W-1:0] rev0,
  output logic      [EVENT_W-1:0] rev1,
  output logic      [PARAM_W-1:0] rpar0
);

  logic [EVENT_W-1:0] ev_mem  [DEPTH];
  logic [PARAM_W-1:0] par_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ev_mem[wa]  <= wev;
      par_mem[wa] <= wpar;
    end
    rev0  <= ev_mem[ra0];
    rev1  <= ev_mem[ra1];
    rpar0 <= par_mem[ra0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/scoh_counter_ram.sv =====
// Occupancy counter store: one write port and one registered read port.
// Uses scoh_pkg for the counter width.
`default_nettype none

module scoh_counter_ram
  import scoh_pkg::*;
#(
  parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF * MAX_BINS_DEF,
  parameter int ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF * MAX_BINS_DEF)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  wa,
  input  wire logic [COUNT_W-1:0] wd,
  input  wire logic [ADDR_W-1:0]  ra,
  output logic      [COUNT_W-1:0] rd
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

// ===== rtl/core/scoh_mac.sv =====
// Shared multiply-add unit for counter address arithmetic: y = addend + a * b.
// Result registered on enable; uses scoh_pkg for the default width.
`default_nettype none

module scoh_mac
  import scoh_pkg::*;
#(
  parameter int WIDTH = $clog2(COLUMNS_DEF * ROWS_DEF * MAX_BINS_DEF)
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] addend,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic      [WIDTH-1:0] y
);

  logic [2*WIDTH-1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      y <= addend + prod[WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scoh_seq.sv =====
// Sequencer: range checks, forward step search, bin check, counter
// read-modify-write, store clearing pass and output register. Uses scoh_pkg.
`default_nettype none

module scoh_seq
  import scoh_pkg::*;
#(
  parameter int COLUMNS     = COLUMNS_DEF,
  parameter int ROWS        = ROWS_DEF,
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int MAX_STEPS   = MAX_STEPS_DEF,
  parameter int STEP_W      = $clog2(MAX_STEPS_DEF),
  parameter int STORE_DEPTH = COLUMNS_DEF * ROWS_DEF * MAX_BINS_DEF,
  parameter int ADDR_W      = $clog2(COLUMNS_DEF * ROWS_DEF * MAX_BINS_DEF)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic [COLUMN_W-1:0] in_column,
  input  wire logic [ROW_W-1:0]    in_row,
  input  wire logic [EVENT_W-1:0]  in_event,
  input  wire logic [SIDX_W-1:0]   in_step_index,
  input  wire logic [EVENT_W-1:0]  in_step_first_event,
  input  wire logic [PARAM_W-1:0]  in_step_parameter,
  input  wire logic [RBIN_W-1:0]   in_read_bin,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_count,
  output logic [RBIN_W-1:0]        out_bin,
  output logic                     tbl_we,
  output logic [STEP_W-1:0]        tbl_wa,
  output logic [EVENT_W-1:0]       tbl_wev,
  output logic [PARAM_W-1:0]       tbl_wpar,
  output logic [STEP_W-1:0]        tbl_ra0,
  output logic [STEP_W-1:0]        tbl_ra1,
  input  wire logic [EVENT_W-1:0]  tbl_rev0,
  input  wire logic [EVENT_W-1:0]  tbl_rev1,
  input  wire logic [PARAM_W-1:0]  tbl_rpar0,
  output logic                     mac_en,
  output logic [ADDR_W-1:0]        mac_addend,
  output logic [ADDR_W-1:0]        mac_a,
  output logic [ADDR_W-1:0]        mac_b,
  input  wire logic [ADDR_W-1:0]   mac_y,
  output logic                     ram_we,
  output logic [ADDR_W-1:0]        ram_wa,
  output logic [COUNT_W-1:0]       ram_wd,
  output logic [ADDR_W-1:0]        ram_ra,
  input  wire logic [COUNT_W-1:0]  ram_rd
);

  state_t state, state_next;

  logic [ADDR_W-1:0]   clr_addr;
  logic [STEP_W-1:0]   search_pointer;
  logic [STEP_W-1:0]   step_i;
  logic [FUNC_W-1:0]   func_q;
  logic [COLUMN_W-1:0] column_q;
  logic [ROW_W-1:0]    row_q;
  logic [EVENT_W-1:0]  event_q;
  logic [RBIN_W-1:0]   read_bin_q;
  logic [PARAM_W-1:0]  par_q;
  logic [BIN_W-1:0]    bin_q;
  logic [STATUS_W-1:0] res_status;
  logic [COUNT_W-1:0]  res_count;
  logic [RBIN_W-1:0]   res_bin;

  logic [STEP_W:0]     steps_used;
  logic [STEP_W:0]     next_i;
  logic                col_ok;
  logic                row_ok;
  logic [COLUMN_W-1:0] col_idx;
  logic [ROW_W-1:0]    row_idx;
  logic [DIFF_W-1:0]   chk_bin;
  logic [DIFF_W-1:0]   diff;
  logic                step_found;
  logic                out_free;

  always_comb begin
    if (cfg.step_count == 9'd0) begin
      steps_used = (STEP_W+1)'(1);
    end else if (32'(cfg.step_count) > 32'(MAX_STEPS)) begin
      steps_used = (STEP_W+1)'(MAX_STEPS);
    end else begin
      steps_used = (STEP_W+1)'(cfg.step_count);
    end
  end

  assign next_i     = {1'b0, step_i} + (STEP_W+1)'(1);
  assign col_idx    = column_q - COLUMN_W'(1);
  assign row_idx    = row_q - ROW_W'(1);
  assign col_ok     = (column_q != '0) && ({1'b0, column_q} <= (COLUMN_W+1)'(COLUMNS));
  assign row_ok     = (row_q != '0) && ({1'b0, row_q} <= (ROW_W+1)'(ROWS));
  assign chk_bin    = (func_q == FUNC_READ) ? DIFF_W'(read_bin_q) : '0;
  assign diff       = {1'b0, par_q} - {1'b0, cfg.min_parameter};
  assign step_found = (tbl_rev1 > event_q) || (tbl_rev1 < tbl_rev0);
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_func == FUNC_HIT || in_func == FUNC_READ) ? S_CHECK : S_DONE;
        end
      end
      S_CHECK: begin
        if (!col_ok || !row_ok) begin
          state_next = S_DONE;
        end else if (func_q == FUNC_HIT && cfg.scan_enabled) begin
          state_next = S_SRCH_RD;
        end else if (bin_ok(chk_bin, cfg.bins_in_use, MAX_BINS)) begin
          state_next = S_ADDR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SRCH_RD:  state_next = (next_i < steps_used) ? S_SRCH_CMP : S_TAIL_RD;
      S_SRCH_CMP: state_next = step_found ? S_BIN : S_SRCH_RD;
      S_TAIL_RD:  state_next = S_TAIL_CMP;
      S_TAIL_CMP: state_next = (tbl_rev0 <= event_q) ? S_BIN : S_DONE;
      S_BIN: begin
        state_next = bin_ok(diff, cfg.bins_in_use, MAX_BINS) ? S_ADDR : S_DONE;
      end
      S_ADDR:    state_next = S_MEM_RD;
      S_MEM_RD:  state_next = S_MEM_CHK;
      S_MEM_CHK: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    tbl_we     = 1'b0;
    tbl_wa     = STEP_W'(in_step_index);
    tbl_wev    = in_step_first_event;
    tbl_wpar   = in_step_parameter;
    tbl_ra0    = step_i;
    tbl_ra1    = next_i[STEP_W-1:0];
    mac_en     = 1'b0;
    mac_addend = mac_y;
    mac_a      = ADDR_W'(bin_q);
    mac_b      = ADDR_W'(COLUMNS * ROWS);
    ram_we     = 1'b0;
    ram_wa     = mac_y;
    ram_wd     = ram_rd + COUNT_W'(1);
    ram_ra     = mac_y;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_addr;
        ram_wd = '0;
      end
      S_IDLE: begin
        tbl_we = in_valid && (in_func == FUNC_LOAD) &&
                 (32'(in_step_index) < 32'(MAX_STEPS));
      end
      S_CHECK: begin
        mac_en     = 1'b1;
        mac_addend = ADDR_W'(col_idx);
        mac_a      = ADDR_W'(row_idx);
        mac_b      = ADDR_W'(COLUMNS);
      end
      S_TAIL_RD: begin
        tbl_ra0 = STEP_W'(steps_used - (STEP_W+1)'(1));
      end
      S_ADDR: begin
        mac_en = 1'b1;
      end
      S_MEM_CHK: begin
        ram_we = (func_q == FUNC_HIT);
      end
      S_SRCH_RD, S_SRCH_CMP, S_TAIL_CMP, S_BIN, S_MEM_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      search_pointer <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
        S_IDLE: begin
          func_q     <= in_func;
          column_q   <= in_column;
          row_q      <= in_row;
          event_q    <= in_event;
          read_bin_q <= in_read_bin;
          res_status <= ST_OK;
          res_count  <= '0;
          res_bin    <= '0;
        end
        S_CHECK: begin
          step_i <= search_pointer;
          bin_q  <= BIN_W'(chk_bin);
          if (!col_ok) begin
            res_status <= ST_COLUMN;
          end else if (!row_ok) begin
            res_status <= ST_ROW;
          end else if (!(func_q == FUNC_HIT && cfg.scan_enabled) &&
                       !bin_ok(chk_bin, cfg.bins_in_use, MAX_BINS)) begin
            res_status <= ST_BIN;
          end
        end
        S_SRCH_CMP: begin
          if (step_found) begin
            search_pointer <= step_i;
            par_q          <= tbl_rpar0;
          end else begin
            step_i <= next_i[STEP_W-1:0];
          end
        end
        S_TAIL_CMP: begin
          if (tbl_rev0 <= event_q) begin
            par_q <= tbl_rpar0;
          end else begin
            res_status <= ST_CORR;
          end
        end
        S_BIN: begin
          bin_q <= BIN_W'(diff);
          if (!bin_ok(diff, cfg.bins_in_use, MAX_BINS)) begin
            res_status <= ST_BIN;
          end
        end
        S_MEM_CHK: begin
          res_count <= (func_q == FUNC_HIT) ? ram_rd + COUNT_W'(1) : ram_rd;
          res_bin   <= RBIN_W'(bin_q);
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_count  <= res_count;
            out_bin    <= res_bin;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scan_occupancy_histogram.sv =====
// Scan occupancy histogram. A load goes straight to the result; a read or unscanned hit
// runs the range and bin checks, the address and the counter access; a scanned hit first
// searches the step table forward, or takes the last step; error results come sooner.
// A new beat can be accepted in the same cycle a result appears, even while it waits.
// Reset (rst, synchronous) clears the search pointer and registers, then a pass zeroes
// all COLUMNS*ROWS*MAX_BINS counters (860160 by default) with tready low.
`default_nettype none

module scan_occupancy_histogram
  import scoh_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int MAX_BINS  = MAX_BINS_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // column[7:0], row[16:8], event_number[48:17], step_index[56:49],
  // step_first_event[88:57], step_parameter[104:89], read_bin[109:105]
  input  wire logic [111:0]          s_axis_tdata,
  // func[1:0]
  input  wire logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // count[31:0], bin[36:32]
  output logic [39:0]                m_axis_tdata,
  // status[2:0]
  output logic [STATUS_W-1:0]        m_axis_tuser
);

  localparam int STORE_DEPTH = COLUMNS * ROWS * MAX_BINS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int STEP_W      = $clog2(MAX_STEPS);

  cfg_t cfg;

  logic                tbl_we;
  logic [STEP_W-1:0]   tbl_wa;
  logic [EVENT_W-1:0]  tbl_wev;
  logic [PARAM_W-1:0]  tbl_wpar;
  logic [STEP_W-1:0]   tbl_ra0;
  logic [STEP_W-1:0]   tbl_ra1;
  logic [EVENT_W-1:0]  tbl_rev0;
  logic [EVENT_W-1:0]  tbl_rev1;
  logic [PARAM_W-1:0]  tbl_rpar0;
  logic                mac_en;
  logic [ADDR_W-1:0]   mac_addend;
  logic [ADDR_W-1:0]   mac_a;
  logic [ADDR_W-1:0]   mac_b;
  logic [ADDR_W-1:0]   mac_y;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_wa;
  logic [COUNT_W-1:0]  ram_wd;
  logic [ADDR_W-1:0]   ram_ra;
  logic [COUNT_W-1:0]  ram_rd;
  logic [COUNT_W-1:0]  out_count;
  logic [RBIN_W-1:0]   out_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_enabled  <= 1'b0;
      cfg.step_count    <= 9'd1;
      cfg.min_parameter <= '0;
      cfg.bins_in_use   <= 6'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCAN_ENABLED:  cfg.scan_enabled  <= cfg_wdata[0];
        REG_STEP_COUNT:    cfg.step_count    <= cfg_wdata[8:0];
        REG_MIN_PARAMETER: cfg.min_parameter <= cfg_wdata[15:0];
        REG_BINS_IN_USE:   cfg.bins_in_use   <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  scoh_seq #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .MAX_BINS    (MAX_BINS),
    .MAX_STEPS   (MAX_STEPS),
    .STEP_W      (STEP_W),
    .STORE_DEPTH (STORE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .in_valid            (s_axis_tvalid),
    .in_ready            (s_axis_tready),
    .in_func             (s_axis_tuser),
    .in_column           (s_axis_tdata[7:0]),
    .in_row              (s_axis_tdata[16:8]),
    .in_event            (s_axis_tdata[48:17]),
    .in_step_index       (s_axis_tdata[56:49]),
    .in_step_first_event (s_axis_tdata[88:57]),
    .in_step_parameter   (s_axis_tdata[104:89]),
    .in_read_bin         (s_axis_tdata[109:105]),
    .out_valid           (m_axis_tvalid),
    .out_ready           (m_axis_tready),
    .out_status          (m_axis_tuser),
    .out_count           (out_count),
    .out_bin             (out_bin),
    .tbl_we              (tbl_we),
    .tbl_wa              (tbl_wa),
    .tbl_wev             (tbl_wev),
    .tbl_wpar            (tbl_wpar),
    .tbl_ra0             (tbl_ra0),
    .tbl_ra1             (tbl_ra1),
    .tbl_rev0            (tbl_rev0),
    .tbl_rev1            (tbl_rev1),
    .tbl_rpar0           (tbl_rpar0),
    .mac_en              (mac_en),
    .mac_addend          (mac_addend),
    .mac_a               (mac_a),
    .mac_b               (mac_b),
    .mac_y               (mac_y),
    .ram_we              (ram_we),
    .ram_wa              (ram_wa),
    .ram_wd              (ram_wd),
    .ram_ra              (ram_ra),
    .ram_rd              (ram_rd)
  );

  scoh_step_table #(
    .DEPTH  (MAX_STEPS),
    .ADDR_W (STEP_W)
  ) u_step_table (
    .clk   (clk),
    .we    (tbl_we),
    .wa    (tbl_wa),
    .wev   (tbl_wev),
    .wpar  (tbl_wpar),
    .ra0   (tbl_ra0),
    .ra1   (tbl_ra1),
    .rev0  (tbl_rev0),
    .rev1  (tbl_rev1),
    .rpar0 (tbl_rpar0)
  );

  scoh_mac #(
    .WIDTH (ADDR_W)
  ) u_mac (
    .clk    (clk),
    .en     (mac_en),
    .addend (mac_addend),
    .a      (mac_a),
    .b      (mac_b),
    .y      (mac_y)
  );

  scoh_counter_ram #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_counter_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  assign m_axis_tdata = {3'b000, out_bin, out_count};

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for scan_occupancy_histogram: directed and random beats
// with random stalls on both streams, checked against an in-bench predictor.
// Depends on scoh_pkg and the scan_occupancy_histogram RTL only.
`default_nettype none

module tb;
  import scoh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned STORE_DEPTH = COLUMNS_DEF * ROWS_DEF * MAX_BINS_DEF;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [4:0]        read_bin;
    logic [15:0]       step_parameter;
    logic [31:0]       step_first_event;
    logic [7:0]        step_index;
    logic [31:0]       event_number;
    logic [8:0]        row;
    logic [7:0]        column;
  } beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [31:0]         count;
    logic [4:0]          bin;
  } outcome_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [111:0]          s_axis_tdata;
  logic [FUNC_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [39:0]           m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // Predictor state: counters, scan table, search position and registers.
  bit [31:0]   occupancy [STORE_DEPTH];
  bit [31:0]   step_first [MAX_STEPS_DEF];
  bit [15:0]   step_param [MAX_STEPS_DEF];
  int unsigned search_pos;
  bit          scan_on;
  logic [8:0]  step_limit;
  logic [15:0] low_param;
  logic [5:0]  bin_limit;

  outcome_t    pending_outcomes [$];
  int unsigned mismatch_count;
  bit          steady;
  logic [31:0] next_event;

  scan_occupancy_histogram DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit find_parameter(input logic [31:0] ev, output int unsigned value);
    int unsigned n;
    int unsigned i;
    n = (step_limit == 0) ? 1 : ((step_limit > MAX_STEPS_DEF) ? MAX_STEPS_DEF : step_limit);
    for (i = search_pos; i + 1 < n; i++) begin
      if (step_first[i + 1] > ev || step_first[i + 1] < step_first[i]) begin
        search_pos = i;
        value = step_param[i];
        return 1'b1;
      end
    end
    value = step_param[n - 1];
    return step_first[n - 1] <= ev;
  endfunction

  function automatic outcome_t predict_histogram(input beat_t b);
    outcome_t    r;
    int unsigned c;
    int unsigned rw;
    int unsigned value;
    int unsigned bv;
    int unsigned addr;
    r = '0;
    if (b.func == FUNC_LOAD) begin
      step_first[b.step_index] = b.step_first_event;
      step_param[b.step_index] = b.step_parameter;
    end else if (b.func == FUNC_HIT || b.func == FUNC_READ) begin
      c = (32'(b.column) - 32'd1) & 32'hFFFF;
      rw = 32'(b.row) - 32'd1;
      if (c > COLUMNS_DEF - 1) begin
        r.status = ST_COLUMN;
      end else if (rw > ROWS_DEF - 1) begin
        r.status = ST_ROW;
      end else begin
        bv = 0;
        if (b.func == FUNC_READ) begin
          bv = b.read_bin;
        end else if (scan_on) begin
          if (!find_parameter(b.event_number, value)) r.status = ST_CORR;
          else bv = value - 32'(low_param);
        end
        if (r.status == ST_OK && !(bv < bin_limit && bv < MAX_BINS_DEF)) r.status = ST_BIN;
        if (r.status == ST_OK) begin
          addr = c + rw * COLUMNS_DEF + bv * COLUMNS_DEF * ROWS_DEF;
          if (b.func == FUNC_HIT) occupancy[addr] = occupancy[addr] + 32'd1;
          r.count = occupancy[addr];
          r.bin = bv[4:0];
        end
      end
    end
    return r;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.func = FUNC_W'($urandom_range(3));
    b.column = 8'($urandom_range(255));
    b.row = 9'($urandom_range(511));
    b.event_number = $urandom;
    b.step_index = 8'($urandom_range(255));
    b.step_first_event = $urandom;
    b.step_parameter = 16'($urandom_range(65535));
    b.read_bin = 5'($urandom_range(31));
    return b;
  endfunction

  function automatic beat_t make_beat(input logic [FUNC_W-1:0] func, input logic [7:0] col,
                                      input logic [8:0] row, input logic [31:0] ev);
    beat_t b;
    b = random_beat();
    b.func = func;
    b.column = col;
    b.row = row;
    b.event_number = ev;
    return b;
  endfunction

  // Mostly a few busy pixels so that counters climb; some anywhere in range or beyond.
  function automatic beat_t on_pixel(input beat_t b);
    case ($urandom_range(9))
      0: ;
      1, 2: begin
        b.column = 8'($urandom_range(1, COLUMNS_DEF));
        b.row = 9'($urandom_range(1, ROWS_DEF));
      end
      default: begin
        case ($urandom_range(3))
          0: b.column = 8'd1;
          1: b.column = 8'd17;
          2: b.column = 8'd41;
          default: b.column = 8'(COLUMNS_DEF);
        endcase
        case ($urandom_range(3))
          0: b.row = 9'd1;
          1: b.row = 9'd7;
          2: b.row = 9'd200;
          default: b.row = 9'(ROWS_DEF);
        endcase
      end
    endcase
    return b;
  endfunction

  task automatic send_beat(input beat_t b);
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= b.func;
    s_axis_tdata <= {2'b00, b.read_bin, b.step_parameter, b.step_first_event, b.step_index,
                     b.event_number, b.row, b.column};
    do @(posedge clk); while (!s_axis_tready);
    pending_outcomes.push_back(predict_histogram(b));
  endtask

  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input bit scan, input logic [8:0] steps,
                              input logic [15:0] minp, input logic [5:0] bin_cnt);
    cfg_we <= 1'b1;
    cfg_index <= REG_SCAN_ENABLED;
    cfg_wdata <= CFG_DATA_W'(scan);
    @(posedge clk);
    cfg_index <= REG_STEP_COUNT;
    cfg_wdata <= CFG_DATA_W'(steps);
    @(posedge clk);
    cfg_index <= REG_MIN_PARAMETER;
    cfg_wdata <= CFG_DATA_W'(minp);
    @(posedge clk);
    cfg_index <= REG_BINS_IN_USE;
    cfg_wdata <= CFG_DATA_W'(bin_cnt);
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_on = scan;
    step_limit = steps;
    low_param = minp;
    bin_limit = bin_cnt;
  endtask

  task automatic send_load(input logic [7:0] idx, input logic [31:0] first_ev,
                           input logic [15:0] param);
    beat_t b;
    b = random_beat();
    b.func = FUNC_LOAD;
    b.step_index = idx;
    b.step_first_event = first_ev;
    b.step_parameter = param;
    send_beat(b);
  endtask

  task automatic test_reset_defaults();
    beat_t b;
    send_beat(make_beat(FUNC_HIT, 8'd1, 9'd1, 32'd0));
    send_beat(make_beat(FUNC_HIT, 8'd1, 9'd1, 32'hFFFF_FFFF));
    send_beat(make_beat(FUNC_HIT, 8'(COLUMNS_DEF), 9'(ROWS_DEF), 32'd5));
    b = make_beat(FUNC_READ, 8'd1, 9'd1, 32'd0);
    b.read_bin = 5'd0;
    send_beat(b);
    b.read_bin = 5'd31;
    send_beat(b);
    send_beat(make_beat(FUNC_HIT, 8'd0, 9'd1, 32'd0));
    send_beat(make_beat(FUNC_HIT, 8'(COLUMNS_DEF + 1), 9'd1, 32'd0));
    send_beat(make_beat(FUNC_HIT, 8'd255, 9'd3, 32'd0));
    send_beat(make_beat(FUNC_HIT, 8'd0, 9'd0, 32'd0));
    send_beat(make_beat(FUNC_HIT, 8'd3, 9'd0, 32'd0));
    send_beat(make_beat(FUNC_HIT, 8'd3, 9'(ROWS_DEF + 1), 32'd0));
    send_beat(make_beat(FUNC_READ, 8'd3, 9'd511, 32'd0));
    send_beat(make_beat(FUNC_UNUSED, 8'd1, 9'd1, 32'd0));
    send_load(8'd255, $urandom, 16'($urandom_range(65535)));
  endtask

  task automatic test_register_extremes();
    beat_t b;
    await_results();
    program_regs(1'b0, 9'd1, 16'd0, 6'd0);
    send_beat(make_beat(FUNC_HIT, 8'd1, 9'd1, 32'd0));
    send_beat(make_beat(FUNC_READ, 8'd1, 9'd1, 32'd0));
    await_results();
    program_regs(1'b1, 9'd0, 16'hFFFF, 6'd63);
    send_load(8'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(make_beat(FUNC_HIT, 8'd2, 9'd2, 32'hFFFF_FFFE));
    send_beat(make_beat(FUNC_HIT, 8'(COLUMNS_DEF), 9'(ROWS_DEF), 32'hFFFF_FFFF));
    send_load(8'd0, 32'd0, 16'd0);
    send_beat(make_beat(FUNC_HIT, 8'd2, 9'd2, 32'd0));
    await_results();
    program_regs(1'b1, 9'd2, 16'd0, 6'd32);
    send_load(8'd1, 32'd100, 16'd31);
    send_beat(make_beat(FUNC_HIT, 8'd5, 9'd5, 32'd99));
    send_beat(make_beat(FUNC_HIT, 8'd5, 9'd5, 32'd100));
    b = make_beat(FUNC_READ, 8'd5, 9'd5, 32'd0);
    b.read_bin = 5'd31;
    send_beat(b);
    await_results();
    program_regs(1'b1, 9'd2, 16'd0, 6'd31);
    send_beat(make_beat(FUNC_HIT, 8'd5, 9'd5, 32'd100));
  endtask

  task automatic run_scan_phase(input int unsigned span);
    beat_t       b;
    int unsigned first;
    int unsigned last;
    int unsigned stride;
    int unsigned k;
    int unsigned j;
    int unsigned hits;
    logic [15:0] minp;
    logic [5:0]  bin_cnt;
    logic [8:0]  steps;
    logic [31:0] base;
    logic [31:0] ev;
    await_results();
    first = search_pos;
    last = first + span - 1;
    if (last > MAX_STEPS_DEF - 1) last = MAX_STEPS_DEF - 1;
    minp = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(65000));
    bin_cnt = ($urandom_range(4) == 0) ? 6'd32 : 6'($urandom_range(1, 32));
    steps = (last == MAX_STEPS_DEF - 1) ? 9'($urandom_range(256, 511)) : 9'(last + 1);
    program_regs(1'b1, steps, minp, bin_cnt);
    stride = $urandom_range(1, 6);
    base = next_event;
    for (k = first; k <= last; k++) begin
      b = random_beat();
      b.func = FUNC_LOAD;
      b.step_index = k[7:0];
      b.step_first_event = base + (k - first) * stride;
      if ($urandom_range(11) == 0) b.step_first_event -= $urandom_range(1, 2 * stride);
      case ($urandom_range(19))
        0: b.step_parameter = minp - 16'd1;
        1, 2: b.step_parameter = 16'($urandom_range(65535));
        default: b.step_parameter = minp + 16'($urandom_range(bin_cnt + 1));
      endcase
      send_beat(b);
    end
    ev = base - 2;
    hits = ((span > 40) ? 40 : span) * 4 + 20;
    for (j = 0; j < hits; j++) begin
      b = on_pixel(random_beat());
      case ($urandom_range(24))
        0: b.func = FUNC_UNUSED;
        1, 2, 3: begin
          b.func = FUNC_READ;
          if ($urandom_range(3) != 0) b.read_bin = 5'($urandom_range(bin_cnt - 1));
        end
        4: b.func = FUNC_HIT;
        5: begin
          b.func = FUNC_HIT;
          ev = ev - stride;
          b.event_number = ev;
        end
        default: begin
          b.func = FUNC_HIT;
          if ($urandom_range(3) == 0) ev = ev + stride;
          b.event_number = ev;
        end
      endcase
      send_beat(b);
    end
    next_event = ev + $urandom_range(10, 1000);
  endtask

  task automatic test_scan_sweeps();
    int unsigned p;
    next_event = $urandom_range(1000, 32'h4000_0000);
    for (p = 0; p < 10; p++) begin
      steady = (p == 3);
      if (p == 6) run_scan_phase(1);
      else run_scan_phase($urandom_range(8, 40));
    end
    steady = 1'b0;
    run_scan_phase(MAX_STEPS_DEF);
  endtask

  task automatic test_unscanned_traffic();
    beat_t       b;
    int unsigned s;
    int unsigned j;
    for (s = 0; s < 2; s++) begin
      await_results();
      if (s == 0) program_regs(1'b0, 9'd511, 16'($urandom_range(65535)), 6'd63);
      else program_regs(1'b0, 9'($urandom_range(511)), 16'($urandom_range(65535)),
                        6'($urandom_range(1, 32)));
      for (j = 0; j < 100; j++) begin
        b = on_pixel(random_beat());
        case ($urandom_range(19))
          0: b.func = FUNC_UNUSED;
          1, 2: b.func = FUNC_LOAD;
          3, 4, 5, 6, 7: b.func = FUNC_READ;
          default: b.func = FUNC_HIT;
        endcase
        send_beat(b);
      end
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result beat: status %0d count %0d bin %0d",
                   m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32]);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.count ||
            m_axis_tdata[36:32] !== want.bin) begin
          if (mismatch_count < 10)
            $display("mismatch: expected status %0d count %0d bin %0d, got %0d %0d %0d",
                     want.status, want.count, want.bin,
                     m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32]);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 36);
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SCAN_ENABLED;
    cfg_wdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= FUNC_LOAD;
    m_axis_tready <= 1'b0;
    mismatch_count = 0;
    steady = 1'b0;
    search_pos = 0;
    scan_on = 1'b0;
    step_limit = 9'd1;
    low_param = 16'd0;
    bin_limit = 6'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_scan_sweeps();
    test_unscanned_traffic();
    await_results();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/scoh_pkg.sv
rtl/core/scoh_step_table.sv
rtl/core/scoh_counter_ram.sv
rtl/core/scoh_mac.sv
rtl/core/scoh_seq.sv
rtl/core/scan_occupancy_histogram.sv
tb/sv/tb.sv
